### rtl/core/rwsd_pkg.sv
package rwsd_pkg;

   // decoder phase codes
   localparam logic [1:0] PH_PREFIX = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   // word kind codes
   localparam logic [3:0] KIND_PREFIX     = 4'd0;
   localparam logic [3:0] KIND_HEADER     = 4'd1;
   localparam logic [3:0] KIND_ADC_HIGH   = 4'd2;
   localparam logic [3:0] KIND_ADC_LOW    = 4'd3;
   localparam logic [3:0] KIND_TDC_LEAD   = 4'd4;
   localparam logic [3:0] KIND_TDC_TRAIL  = 4'd5;
   localparam logic [3:0] KIND_SCALER     = 4'd6;
   localparam logic [3:0] KIND_UNKNOWN    = 4'd7;
   localparam logic [3:0] KIND_DATA_ERR   = 4'd8;
   localparam logic [3:0] KIND_HEADER_ERR = 4'd9;

   localparam logic [11:0] THRESHOLD_RESET = 12'hfff;

   typedef struct packed {
      logic [1:0]  phase;
      logic [11:0] words_left;
      logic        odd_record;
      logic        discarding;
   } state_type;

   typedef struct packed {
      logic [3:0]  word_kind;
      logic [6:0]  channel;
      logic [1:0]  plane;
      logic [1:0]  layer;
      logic [3:0]  fiber;
      logic [1:0]  chip;
      logic [13:0] value;
      logic        over_range;
      logic        hit;
      logic [11:0] data_count;
      logic        record_last;
   } result_type;

   typedef struct packed {
      logic [1:0] plane;
      logic       sub;
      logic [3:0] fiber;
   } chmap_type;

   // fiber layout of one 64-channel half
   function automatic chmap_type map_channel(input logic [5:0] c);
      chmap_type  m;
      logic [5:0] f;
      begin
         if (c <= 6'd7) begin
            m.plane = 2'd1; m.sub = 1'b0; f = c;
         end else if (c <= 6'd15) begin
            m.plane = 2'd1; m.sub = 1'b1; f = c - 6'd8;
         end else if (c <= 6'd17) begin
            m.plane = 2'd1; m.sub = 1'b0; f = c - 6'd8;
         end else if (c <= 6'd23) begin
            m.plane = 2'd0; m.sub = 1'b0; f = c - 6'd18;
         end else if (c <= 6'd25) begin
            m.plane = 2'd1; m.sub = 1'b1; f = c - 6'd16;
         end else if (c <= 6'd31) begin
            m.plane = 2'd0; m.sub = 1'b1; f = c - 6'd26;
         end else if (c <= 6'd37) begin
            m.plane = 2'd0; m.sub = 1'b0; f = c - 6'd26;
         end else if (c <= 6'd39) begin
            m.plane = 2'd2; m.sub = 1'b0; f = c - 6'd38;
         end else if (c <= 6'd45) begin
            m.plane = 2'd0; m.sub = 1'b1; f = c - 6'd34;
         end else if (c <= 6'd47) begin
            m.plane = 2'd2; m.sub = 1'b1; f = c - 6'd46;
         end else if (c <= 6'd55) begin
            m.plane = 2'd2; m.sub = 1'b0; f = c - 6'd46;
         end else begin
            m.plane = 2'd2; m.sub = 1'b1; f = c - 6'd54;
         end
         m.fiber = f[3:0];
         return m;
      end
   endfunction

endpackage

### rtl/core/rwsd_decode.sv
module rwsd_decode #(
   parameter int PREFIX_WORDS = 2
) (
   input  logic [31:0]            word,
   input  rwsd_pkg::state_type    state,
   input  logic [11:0]            threshold,
   output rwsd_pkg::result_type   result,
   output rwsd_pkg::state_type    state_next
);

   localparam logic [11:0] PREFIX_LEN = 12'(PREFIX_WORDS);
   localparam logic [1:0]  PH_START   = (PREFIX_WORDS == 0) ? rwsd_pkg::PH_HEADER
                                                            : rwsd_pkg::PH_PREFIX;

   logic [27:0]         dec;
   logic                frame_ok;
   logic [6:0]          chan;
   rwsd_pkg::chmap_type cmap;
   logic [3:0]          kind;
   logic [11:0]         left_dec;
   logic [11:0]         left_inc;

   assign dec      = {word[30:24], word[22:16], word[14:8], word[6:0]};
   assign frame_ok = word[31] & ~word[23] & ~word[15] & ~word[7];
   assign chan     = {state.odd_record, dec[18:13]};
   assign cmap     = rwsd_pkg::map_channel(chan[5:0]);
   assign left_dec = state.words_left - 12'd1;
   assign left_inc = state.words_left + 12'd1;

   // data word classes, first match wins
   always_comb begin
      if ({dec[22], dec[21], dec[19]} == 3'b000) begin
         kind = rwsd_pkg::KIND_ADC_HIGH;
      end else if ({dec[22], dec[21], dec[19]} == 3'b001) begin
         kind = rwsd_pkg::KIND_ADC_LOW;
      end else if ({dec[22], dec[21], dec[12]} == 3'b011) begin
         kind = rwsd_pkg::KIND_TDC_LEAD;
      end else if ({dec[22], dec[21], dec[12]} == 3'b010) begin
         kind = rwsd_pkg::KIND_TDC_TRAIL;
      end else if ({dec[22], dec[21]} == 2'b10) begin
         kind = rwsd_pkg::KIND_SCALER;
      end else begin
         kind = rwsd_pkg::KIND_UNKNOWN;
      end
   end

   always_comb begin
      result     = '0;
      state_next = state;
      case (state.phase)
         rwsd_pkg::PH_HEADER: begin
            if (!frame_ok || !dec[27]) begin
               result.word_kind      = rwsd_pkg::KIND_HEADER_ERR;
               state_next.phase      = PH_START;
               state_next.words_left = '0;
               state_next.discarding = 1'b0;
            end else begin
               result.word_kind  = rwsd_pkg::KIND_HEADER;
               result.data_count = dec[11:0];
               if (dec[11:0] == 12'd0) begin
                  result.record_last    = 1'b1;
                  state_next.odd_record = ~state.odd_record;
                  state_next.phase      = PH_START;
                  state_next.words_left = '0;
                  state_next.discarding = 1'b0;
               end else begin
                  state_next.phase      = rwsd_pkg::PH_DATA;
                  state_next.words_left = dec[11:0];
                  state_next.discarding = 1'b0;
               end
            end
         end
         rwsd_pkg::PH_DATA: begin
            if (state.discarding || !frame_ok) begin
               result.word_kind      = rwsd_pkg::KIND_DATA_ERR;
               state_next.discarding = 1'b1;
            end else begin
               result.word_kind = kind;
               result.channel   = chan;
               result.plane     = cmap.plane;
               result.layer     = {state.odd_record, cmap.sub};
               result.fiber     = cmap.fiber;
               result.chip      = chan[6:5];
               if (kind == rwsd_pkg::KIND_ADC_HIGH || kind == rwsd_pkg::KIND_ADC_LOW) begin
                  result.value      = {2'b00, dec[11:0]};
                  result.over_range = dec[12];
                  result.hit        = (kind == rwsd_pkg::KIND_ADC_HIGH) && !dec[12]
                                      && (dec[11:0] > threshold);
               end else if (kind == rwsd_pkg::KIND_TDC_LEAD
                            || kind == rwsd_pkg::KIND_TDC_TRAIL) begin
                  result.value = {2'b00, dec[11:0]};
               end else if (kind == rwsd_pkg::KIND_SCALER) begin
                  result.value = dec[13:0];
               end
            end
            state_next.words_left = left_dec;
            if (left_dec == 12'd0) begin
               result.record_last    = 1'b1;
               state_next.odd_record = ~state.odd_record;
               state_next.phase      = PH_START;
               state_next.discarding = 1'b0;
            end
         end
         default: begin
            // prefix words are counted, not checked
            result.word_kind      = rwsd_pkg::KIND_PREFIX;
            state_next.phase      = rwsd_pkg::PH_PREFIX;
            state_next.words_left = left_inc;
            if (left_inc >= PREFIX_LEN) begin
               state_next.words_left = '0;
               state_next.phase      = rwsd_pkg::PH_HEADER;
            end
         end
      endcase
   end

endmodule

### rtl/core/readout_word_stream_decoder_core.sv
// readout word stream decoder
// req channel: one 32-bit big-endian readout word per request on req_raw_word,
//   accepted when req_valid is high and req_stall is low
// rsp channel: exactly one result per request (word kind, channel map, value,
//   hit flag, header data count, end of record), accepted when rsp_valid is
//   high and rsp_stall is low
// path: input register, then decode into the result register (rsp_valid)
// throughput: one request per cycle while the result register is not stalled;
//   the only stored loop is the record state (phase, word count, parity,
//   discard flag), updated in one pass
// stalls: a stalled result holds in the result register while the input
//   register still takes one more request; req_stall rises only when both
//   are full and rsp_stall is high
// reset: synchronous, active high; clears both valid flags, puts the decoder
//   in the prefix phase (header phase when no prefix words are configured),
//   even record parity, and hit_threshold to 4095
// config: hit_threshold at byte address 0 over the apb-style port; the user
//   must write it only while no request is in flight (not enforced here)
module readout_word_stream_decoder_core #(
   parameter int PREFIX_WORDS = 2
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_raw_word,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_word_kind,
   output logic [6:0]  rsp_channel,
   output logic [1:0]  rsp_plane,
   output logic [1:0]  rsp_layer,
   output logic [3:0]  rsp_fiber,
   output logic [1:0]  rsp_chip,
   output logic [13:0] rsp_value,
   output logic        rsp_over_range,
   output logic        rsp_hit,
   output logic [11:0] rsp_data_count,
   output logic        rsp_record_last,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [1:0] PH_START = (PREFIX_WORDS == 0) ? rwsd_pkg::PH_HEADER
                                                         : rwsd_pkg::PH_PREFIX;

   // input stage
   logic                 in_valid_ff;
   logic [31:0]          in_word_ff;
   // result stage
   logic                 out_valid_ff;
   rwsd_pkg::result_type out_ff;
   // record state and config
   rwsd_pkg::state_type  state_ff;
   rwsd_pkg::state_type  state_in;
   rwsd_pkg::result_type result_in;
   logic [11:0]          threshold_ff;

   logic advance;
   logic req_take;
   logic csr_write;

   // the input stage moves on whenever the result register is free or draining
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == 1'b0) ? {20'd0, threshold_ff} : 32'd0;

   rwsd_decode #(
      .PREFIX_WORDS(PREFIX_WORDS)
   ) u_decode (
      .word       (in_word_ff),
      .state      (state_ff),
      .threshold  (threshold_ff),
      .result     (result_in),
      .state_next (state_in)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.phase        <= PH_START;
         state_ff.words_left   <= '0;
         state_ff.odd_record   <= 1'b0;
         state_ff.discarding   <= 1'b0;
         threshold_ff          <= rwsd_pkg::THRESHOLD_RESET;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         // record state steps once per word entering the result register
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
         if (csr_write) begin
            threshold_ff <= pwdata[11:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_raw_word;
      end
      if (advance && in_valid_ff) begin
         out_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_word_kind   = out_ff.word_kind;
   assign rsp_channel     = out_ff.channel;
   assign rsp_plane       = out_ff.plane;
   assign rsp_layer       = out_ff.layer;
   assign rsp_fiber       = out_ff.fiber;
   assign rsp_chip        = out_ff.chip;
   assign rsp_value       = out_ff.value;
   assign rsp_over_range  = out_ff.over_range;
   assign rsp_hit         = out_ff.hit;
   assign rsp_data_count  = out_ff.data_count;
   assign rsp_record_last = out_ff.record_last;

   // a hit only comes from an in-range high-gain adc word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_word_kind == rwsd_pkg::KIND_ADC_HIGH && !rsp_over_range)
      else $error("hit flagged on a word that is not an in-range high gain adc");

   // the data phase always has at least one word still due
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == rwsd_pkg::PH_DATA |-> state_ff.words_left != 12'd0)
      else $error("data phase with no words left");

   // discarding only lives inside a record's data words
   assert property (@(posedge clock) disable iff (reset)
      state_ff.discarding |-> state_ff.phase == rwsd_pkg::PH_DATA)
      else $error("discard flag set outside the data phase");

   // a header error never closes a record
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_kind == rwsd_pkg::KIND_HEADER_ERR |-> !rsp_record_last)
      else $error("header error marked as end of record");

   // the record parity only flips when a record end enters the result register
   assert property (@(posedge clock) disable iff (reset)
      state_ff.odd_record != $past(state_ff.odd_record) |-> rsp_valid && rsp_record_last)
      else $error("record parity changed without a record end");

endmodule
